// ----- hw/rtl/arpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache package
// Sizes and command codes shared by the ARP cache, its channels and checker.
// ----------------------------------------------------------------------------
package arpc_pkg;

   // Number of address pairs held in the cache
   localparam int ENTRIES = 8;
   // Index width for the cache table
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;

   typedef logic [IP_W-1:0]  ip_type;
   typedef logic [MAC_W-1:0] mac_type;
   typedef logic [IDX_W-1:0] idx_type;

   // Command codes on the request channel
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_CHECK  = 1'b1;

endpackage

// ----- hw/rtl/arpc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache request channel
// Valid/ready channel that carries one lookup or update command per beat.
// ----------------------------------------------------------------------------
interface arpc_req_if;
   logic              valid;
   logic              ready;
   logic              cmd;
   arpc_pkg::ip_type  ip_addr;
   arpc_pkg::mac_type new_mac;

   modport source (output valid, output cmd, output ip_addr, output new_mac, input ready);
   modport sink   (input valid, input cmd, input ip_addr, input new_mac, output ready);
endinterface

// ----- hw/rtl/arpc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache response channel
// Valid/ready channel that carries the found flag and MAC of one command.
// ----------------------------------------------------------------------------
interface arpc_rsp_if;
   logic              valid;
   logic              ready;
   logic              found;
   arpc_pkg::mac_type mac_out;

   modport source (output valid, output found, output mac_out, input ready);
   modport sink   (input valid, input found, input mac_out, output ready);
endinterface

// ----- hw/rtl/arp_cache_lookup_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache lookup and update
// Small IPv4-to-MAC table with lowest-index match and round-robin refill.
// ----------------------------------------------------------------------------
// The cache holds ENTRIES address pairs, all zero after reset, so a lookup of
// address zero hits the lowest entry not yet refilled. An update beat
// rewrites the MAC of the first matching entry (found = 1) or, on a miss,
// stores the pair at the round-robin pointer (found = 0); its response always
// carries MAC zero. A check beat returns found and the stored MAC, or zero on
// a miss, and leaves the table alone. The table has one read port and one
// address comparator that step through the entries from index zero, a read
// state then a compare state per entry examined, until a match or the last
// entry; an update then passes through a write state. One command is in
// flight at a time; a finished response waits in its output register while
// the next request beat is already taken.
// ----------------------------------------------------------------------------
module arp_cache_lookup_update (
   input  logic        clock,
   input  logic        reset,
   arpc_req_if.sink    req_chan,
   arpc_rsp_if.source  rsp_chan
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam arpc_pkg::idx_type LAST_IDX = arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1);

   // Control state
   logic [2:0]         state_ff, state_in;
   arpc_pkg::idx_type  idx_ff, idx_in;
   arpc_pkg::idx_type  ptr_ff, ptr_in;
   logic               found_ff, found_in;
   arpc_pkg::mac_type  res_mac_ff, res_mac_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [arpc_pkg::ENTRIES-1:0] vld_ff;

   // Payload registers
   logic               cmd_ff;
   arpc_pkg::ip_type   key_ff;
   arpc_pkg::mac_type  mac_ff;
   logic               rsp_found_ff;
   arpc_pkg::mac_type  rsp_mac_ff;

   // Table and its read data
   arpc_pkg::ip_type   ip_mem  [arpc_pkg::ENTRIES];
   arpc_pkg::mac_type  mac_mem [arpc_pkg::ENTRIES];
   arpc_pkg::ip_type   rd_ip_ff;
   arpc_pkg::mac_type  rd_mac_ff;
   logic               rd_vld_ff;

   logic               accept;
   logic               rsp_free;
   logic               wr_en;
   arpc_pkg::idx_type  wr_idx;
   arpc_pkg::ip_type   eff_ip;
   arpc_pkg::mac_type  eff_mac;
   logic               hit;
   logic               last;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_free         = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.found   = rsp_found_ff;
   assign rsp_chan.mac_out = rsp_mac_ff;

   // Entries never written read as zero
   assign eff_ip  = rd_vld_ff ? rd_ip_ff  : '0;
   assign eff_mac = rd_vld_ff ? rd_mac_ff : '0;
   assign hit     = (eff_ip == key_ff);
   assign last    = (idx_ff == LAST_IDX);

   // Hit rewrites the matching entry, miss refills at the pointer
   assign wr_en  = (state_ff == ST_WRITE);
   assign wr_idx = found_ff ? idx_ff : ptr_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      found_in     = found_ff;
      res_mac_in   = res_mac_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (hit) begin
               found_in   = 1'b1;
               res_mac_in = (cmd_ff == arpc_pkg::CMD_CHECK) ? eff_mac : '0;
               state_in   = (cmd_ff == arpc_pkg::CMD_CHECK) ? ST_DONE : ST_WRITE;
            end else if (last) begin
               found_in   = 1'b0;
               res_mac_in = '0;
               state_in   = (cmd_ff == arpc_pkg::CMD_CHECK) ? ST_DONE : ST_WRITE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_WRITE: begin
            // Advance the refill pointer on a miss, wrapping at the last entry
            if (!found_ff) begin
               ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         ptr_ff       <= '0;
         found_ff     <= 1'b0;
         res_mac_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         ptr_ff       <= ptr_in;
         found_ff     <= found_in;
         res_mac_ff   <= res_mac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Entry valid bits, cleared together at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_chan.cmd;
         key_ff <= req_chan.ip_addr;
         mac_ff <= req_chan.new_mac;
      end
   end

   // Load the response register once the slot is free
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_found_ff <= found_ff;
         rsp_mac_ff   <= res_mac_ff;
      end
   end

   // Table: one write port, one registered read port at the scan index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ip_mem[wr_idx]  <= key_ff;
         mac_mem[wr_idx] <= mac_ff;
      end
      rd_ip_ff  <= ip_mem[idx_ff];
      rd_mac_ff <= mac_mem[idx_ff];
      rd_vld_ff <= vld_ff[idx_ff];
   end

endmodule

// ----- hw/rtl/arpc_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache port checker
// Watches the request and response ports of the ARP cache over time.
// ----------------------------------------------------------------------------
module arpc_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_found,
   input arpc_pkg::mac_type rsp_mac_out
);

   // One command in flight: ready drops right after a request beat
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a command is in flight");

   // A miss never returns a MAC
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_mac_out == '0))
      else $error("response without a match carries a MAC");

   // No response beat straight out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_mac_out)))
      else $error("stalled response changed or dropped");

endmodule

bind arp_cache_lookup_update arpc_chk u_arpc_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_found   (rsp_chan.found),
   .rsp_mac_out (rsp_chan.mac_out)
);
